// File: rtl/dual_encoder_pid_velocity_drive_assert.svh
// Assertion macros shared by the drive's RTL.
`ifndef DUAL_ENCODER_PID_VELOCITY_DRIVE_ASSERT_SVH
`define DUAL_ENCODER_PID_VELOCITY_DRIVE_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define DEP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define DEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dep_pkg.sv
package dep_pkg;

    localparam int STEP_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int ERR_SUM_W  = 32;
    localparam int PROD_PD_W  = 32;
    localparam int PROD_I_W   = 48;
    localparam int SUM_W      = 50;
    localparam int ACC_FRAC   = 8;
    localparam int ACC_W      = 18;
    localparam int U_W        = 19;
    localparam int DUTY_W     = 8;
    localparam int PIN_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Operation codes of an input item.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RIGHT = 3'd4;

    // Reset gains: P 0.75, I 0 and D 90/256 in Q8.8.
    localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = 16'sd192;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RESET = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RESET = 16'sd90;

    // Pin positions in a sample.
    localparam logic [PIN_W-1:0] PIN_RIGHT_A = 4'h1;
    localparam logic [PIN_W-1:0] PIN_RIGHT_B = 4'h2;
    localparam logic [PIN_W-1:0] PIN_LEFT_A  = 4'h4;
    localparam logic [PIN_W-1:0] PIN_LEFT_B  = 4'h8;

    typedef struct packed {
        logic             op;
        logic [PIN_W-1:0] pin_sample;
    } cmd_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]        left_duty;
        logic                     left_reverse;
        logic [DUTY_W-1:0]        right_duty;
        logic                     right_reverse;
        logic signed [STEP_W-1:0] left_velocity;
        logic signed [STEP_W-1:0] right_velocity;
    } report_item_t;

    // Load strobes of the PID pipeline stages.
    typedef struct packed {
        logic load_err;
        logic load_mult;
        logic load_sum;
        logic load_acc;
    } lane_ctl_t;

endpackage

// File: rtl/dep_if.sv
interface dep_cmd_if;
    import dep_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dep_report_if;
    import dep_pkg::*;

    logic         valid;
    logic         ready;
    report_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/dual_encoder_pid_velocity_drive.sv
// Two-wheel quadrature encoder counter with a velocity PID drive per wheel.
// The block takes one item in every clock cycle while ready is high. A pin
// sample item updates the step counts at once and gives no result. A tick
// item captures and clears both step counts and runs both PID loops through
// a four-stage pipeline (error and integral, gain multipliers, sum and
// rescale, accumulator clamp into the output register), from which its
// result is reported. Up to four ticks may be in flight; when the result
// register is held by a stalled consumer, the pipeline fills and then ready
// drops for items of both kinds.
// Configuration writes are meant for an idle block.
`include "dual_encoder_pid_velocity_drive_assert.svh"

module dual_encoder_pid_velocity_drive
#(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int DUTY_LIMIT     = 255
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    dep_cmd_if.sink                             cmd,
    dep_report_if.source                        report,
    input  logic                                cfg_wen,
    input  logic [dep_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [dep_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import dep_pkg::*;

    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic signed [STEP_W-1:0] target_left_reg;
    logic signed [STEP_W-1:0] target_right_reg;

    logic                     err_valid_reg;
    logic                     err_valid_next;
    logic                     mult_valid_reg;
    logic                     mult_valid_next;
    logic                     sum_valid_reg;
    logic                     sum_valid_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    logic                     ready_err;
    logic                     ready_mult;
    logic                     ready_sum;
    logic                     ready_out;
    logic                     accept;
    logic                     sample_en;
    lane_ctl_t                ctl;

    logic signed [STEP_W-1:0] left_steps;
    logic signed [STEP_W-1:0] right_steps;
    logic signed [ACC_W-1:0]  left_drive;
    logic signed [ACC_W-1:0]  right_drive;

    logic signed [STEP_W-1:0] left_vel_err_reg;
    logic signed [STEP_W-1:0] right_vel_err_reg;
    logic signed [STEP_W-1:0] left_vel_mult_reg;
    logic signed [STEP_W-1:0] right_vel_mult_reg;
    logic signed [STEP_W-1:0] left_vel_sum_reg;
    logic signed [STEP_W-1:0] right_vel_sum_reg;
    report_item_t             out_reg;
    report_item_t             out_next;

    function automatic logic [DUTY_W-1:0] duty_of(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0] mag;
        mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        return mag[ACC_FRAC+DUTY_W-1:ACC_FRAC];
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg       <= GAIN_P_RESET;
            gain_i_reg       <= GAIN_I_RESET;
            gain_d_reg       <= GAIN_D_RESET;
            target_left_reg  <= '0;
            target_right_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                REG_GAIN_P:       gain_p_reg       <= cfg_wdata;
                REG_GAIN_I:       gain_i_reg       <= cfg_wdata;
                REG_GAIN_D:       gain_d_reg       <= cfg_wdata;
                REG_TARGET_LEFT:  target_left_reg  <= cfg_wdata;
                REG_TARGET_RIGHT: target_right_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Pipeline flow control: a stage takes a new item when it is empty or
    // its item moves on in the same cycle.
    always_comb
    begin
        ready_out  = !out_valid_reg || report.ready;
        ready_sum  = !sum_valid_reg || ready_out;
        ready_mult = !mult_valid_reg || ready_sum;
        ready_err  = !err_valid_reg || ready_mult;
        accept     = cmd.valid && ready_err;
        sample_en  = accept && (cmd.payload.op == OP_SAMPLE);

        ctl.load_err  = accept && (cmd.payload.op == OP_TICK);
        ctl.load_mult = err_valid_reg && ready_mult;
        ctl.load_sum  = mult_valid_reg && ready_sum;
        ctl.load_acc  = sum_valid_reg && ready_out;

        err_valid_next  = ctl.load_err || (err_valid_reg && !ready_mult);
        mult_valid_next = ctl.load_mult || (mult_valid_reg && !ready_sum);
        sum_valid_next  = ctl.load_sum || (sum_valid_reg && !ready_out);
        out_valid_next  = ctl.load_acc || (out_valid_reg && !report.ready);
    end

    assign cmd.ready = ready_err;

    dep_encoder u_encoder
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_en   (sample_en),
        .clear_en    (ctl.load_err),
        .pins        (cmd.payload.pin_sample),
        .left_steps  (left_steps),
        .right_steps (right_steps)
    );

    dep_pid_lane
    #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .DUTY_LIMIT     (DUTY_LIMIT)
    )
    u_left_lane
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .steps  (left_steps),
        .target (target_left_reg),
        .gain_p (gain_p_reg),
        .gain_i (gain_i_reg),
        .gain_d (gain_d_reg),
        .drive  (left_drive)
    );

    dep_pid_lane
    #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .DUTY_LIMIT     (DUTY_LIMIT)
    )
    u_right_lane
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .steps  (right_steps),
        .target (target_right_reg),
        .gain_p (gain_p_reg),
        .gain_i (gain_i_reg),
        .gain_d (gain_d_reg),
        .drive  (right_drive)
    );

    always_comb
    begin
        out_next.left_duty      = duty_of(left_drive);
        out_next.left_reverse   = left_drive[ACC_W-1];
        out_next.right_duty     = duty_of(right_drive);
        out_next.right_reverse  = right_drive[ACC_W-1];
        out_next.left_velocity  = left_vel_sum_reg;
        out_next.right_velocity = right_vel_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_valid_reg  <= 1'b0;
            mult_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            err_valid_reg  <= err_valid_next;
            mult_valid_reg <= mult_valid_next;
            sum_valid_reg  <= sum_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // The captured step counts ride along with the tick.
    always_ff @(posedge clk)
    begin
        if (ctl.load_err)
        begin
            left_vel_err_reg  <= left_steps;
            right_vel_err_reg <= right_steps;
        end
        if (ctl.load_mult)
        begin
            left_vel_mult_reg  <= left_vel_err_reg;
            right_vel_mult_reg <= right_vel_err_reg;
        end
        if (ctl.load_sum)
        begin
            left_vel_sum_reg  <= left_vel_mult_reg;
            right_vel_sum_reg <= right_vel_mult_reg;
        end
        if (ctl.load_acc)
        begin
            out_reg <= out_next;
        end
    end

    assign report.valid   = out_valid_reg;
    assign report.payload = out_reg;

    `DEP_ASSERT_IMPLY(a_stall_only_when_full, !cmd.ready,
        err_valid_reg && mult_valid_reg && sum_valid_reg && report.valid && !report.ready,
        "input stalled while the pipeline has room")
    `DEP_ASSERT_IMPLY(a_result_from_pipeline, $rose(report.valid), $past(sum_valid_reg),
        "result appeared without a tick in the sum stage")
    `DEP_ASSERT_NEXT(a_tick_clears_steps, ctl.load_err,
        left_steps == '0 && right_steps == '0,
        "step counts not cleared by a tick")
    `DEP_ASSERT_IMPLY(a_duty_in_limit, report.valid,
        report.payload.left_duty <= DUTY_W'(DUTY_LIMIT)
        && report.payload.right_duty <= DUTY_W'(DUTY_LIMIT),
        "duty above the drive limit")

endmodule

// File: rtl/dep_encoder.sv
module dep_encoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_en,
    input  logic                              clear_en,
    input  logic [dep_pkg::PIN_W-1:0]         pins,
    output logic signed [dep_pkg::STEP_W-1:0] left_steps,
    output logic signed [dep_pkg::STEP_W-1:0] right_steps
);
    import dep_pkg::*;

    logic [PIN_W-1:0]         last_pins_reg;
    logic [PIN_W-1:0]         last_pins_next;
    logic signed [STEP_W-1:0] left_steps_reg;
    logic signed [STEP_W-1:0] left_steps_next;
    logic signed [STEP_W-1:0] right_steps_reg;
    logic signed [STEP_W-1:0] right_steps_next;
    logic [PIN_W-1:0]         delta;
    logic [PIN_W-1:0]         dir;

    always_comb
    begin
        delta            = last_pins_reg ^ pins;
        dir              = (~pins) ^ (last_pins_reg >> 1);
        last_pins_next   = last_pins_reg;
        left_steps_next  = left_steps_reg;
        right_steps_next = right_steps_reg;
        if (clear_en)
        begin
            left_steps_next  = '0;
            right_steps_next = '0;
        end
        else if (sample_en)
        begin
            last_pins_next = pins;
            if ((delta & (PIN_LEFT_A | PIN_LEFT_B)) != '0)
            begin
                if ((dir & PIN_LEFT_A) != '0)
                begin
                    left_steps_next = left_steps_reg - STEP_W'(1);
                end
                else
                begin
                    left_steps_next = left_steps_reg + STEP_W'(1);
                end
            end
            if ((delta & (PIN_RIGHT_A | PIN_RIGHT_B)) != '0)
            begin
                if ((dir & PIN_RIGHT_A) != '0)
                begin
                    right_steps_next = right_steps_reg + STEP_W'(1);
                end
                else
                begin
                    right_steps_next = right_steps_reg - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pins_reg   <= '0;
            left_steps_reg  <= '0;
            right_steps_reg <= '0;
        end
        else
        begin
            last_pins_reg   <= last_pins_next;
            left_steps_reg  <= left_steps_next;
            right_steps_reg <= right_steps_next;
        end
    end

    assign left_steps  = left_steps_reg;
    assign right_steps = right_steps_reg;

endmodule

// File: rtl/dep_pid_lane.sv
module dep_pid_lane
#(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int DUTY_LIMIT     = 255
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  dep_pkg::lane_ctl_t                ctl,
    input  logic signed [dep_pkg::STEP_W-1:0] steps,
    input  logic signed [dep_pkg::STEP_W-1:0] target,
    input  logic signed [dep_pkg::GAIN_W-1:0] gain_p,
    input  logic signed [dep_pkg::GAIN_W-1:0] gain_i,
    input  logic signed [dep_pkg::GAIN_W-1:0] gain_d,
    output logic signed [dep_pkg::ACC_W-1:0]  drive
);
    import dep_pkg::*;

    localparam int SHIFT   = GAIN_FRAC_BITS - ACC_FRAC;
    localparam int RSH     = (SHIFT > 0) ? SHIFT : 0;
    localparam int LSH     = (SHIFT < 0) ? -SHIFT : 0;
    localparam int SCALE_W = SUM_W + LSH;
    localparam int LIM     = DUTY_LIMIT * (1 << ACC_FRAC);

    localparam logic signed [SCALE_W-1:0]   SCALE_HI = SCALE_W'(2 * LIM);
    localparam logic signed [SCALE_W-1:0]   SCALE_LO = -SCALE_HI;
    localparam logic signed [U_W-1:0]       U_MAX    = U_W'(2 * LIM);
    localparam logic signed [U_W-1:0]       U_MIN    = -U_MAX;
    localparam logic signed [U_W-1:0]       A_MAX    = U_W'(LIM);
    localparam logic signed [U_W-1:0]       A_MIN    = -A_MAX;
    localparam logic signed [ERR_SUM_W-1:0] SUM_MAX  = {1'b0, {(ERR_SUM_W-1){1'b1}}};
    localparam logic signed [ERR_SUM_W-1:0] SUM_MIN  = {1'b1, {(ERR_SUM_W-1){1'b0}}};

    // While a tick sits in the error stage, prev_err_reg and err_sum_reg hold
    // its error and its integral; a later tick cannot overwrite them before
    // the multiplier stage has taken them.
    logic signed [STEP_W-1:0]    prev_err_reg;
    logic signed [STEP_W-1:0]    prev_err_next;
    logic signed [ERR_SUM_W-1:0] err_sum_reg;
    logic signed [ERR_SUM_W-1:0] err_sum_next;
    logic signed [STEP_W-1:0]    deriv_reg;
    logic signed [STEP_W-1:0]    deriv_next;
    logic signed [ERR_SUM_W:0]   sum_wide;

    logic signed [PROD_PD_W-1:0] prod_p_reg;
    logic signed [PROD_PD_W-1:0] prod_p_next;
    logic signed [PROD_I_W-1:0]  prod_i_reg;
    logic signed [PROD_I_W-1:0]  prod_i_next;
    logic signed [PROD_PD_W-1:0] prod_d_reg;
    logic signed [PROD_PD_W-1:0] prod_d_next;

    logic signed [SUM_W-1:0]     term_sum;
    logic signed [SCALE_W-1:0]   scaled;
    logic signed [U_W-1:0]       u_reg;
    logic signed [U_W-1:0]       u_next;

    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [U_W-1:0]       acc_sum;

    // Error stage.
    always_comb
    begin
        prev_err_next = target - steps;
        sum_wide      = (ERR_SUM_W+1)'(err_sum_reg) + (ERR_SUM_W+1)'(prev_err_next);
        if (sum_wide[ERR_SUM_W] != sum_wide[ERR_SUM_W-1])
        begin
            err_sum_next = sum_wide[ERR_SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            err_sum_next = sum_wide[ERR_SUM_W-1:0];
        end
        deriv_next = prev_err_next - prev_err_reg;
    end

    // Multiplier stage.
    always_comb
    begin
        prod_p_next = PROD_PD_W'(gain_p) * PROD_PD_W'(prev_err_reg);
        prod_i_next = PROD_I_W'(gain_i) * PROD_I_W'(err_sum_reg);
        prod_d_next = PROD_PD_W'(gain_d) * PROD_PD_W'(deriv_reg);
    end

    // Sum stage: rescale to Q.8 with floor and bound the step.
    always_comb
    begin
        term_sum = SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg) + SUM_W'(prod_d_reg);
        scaled   = (SCALE_W'(term_sum) <<< LSH) >>> RSH;
        if (scaled > SCALE_HI)
        begin
            u_next = U_MAX;
        end
        else if (scaled < SCALE_LO)
        begin
            u_next = U_MIN;
        end
        else
        begin
            u_next = U_W'(scaled);
        end
    end

    // Accumulator stage.
    always_comb
    begin
        acc_sum = U_W'(acc_reg) + u_reg;
        if (acc_sum > A_MAX)
        begin
            drive = ACC_W'(A_MAX);
        end
        else if (acc_sum < A_MIN)
        begin
            drive = ACC_W'(A_MIN);
        end
        else
        begin
            drive = ACC_W'(acc_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            err_sum_reg  <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            if (ctl.load_err)
            begin
                prev_err_reg <= prev_err_next;
                err_sum_reg  <= err_sum_next;
            end
            if (ctl.load_acc)
            begin
                acc_reg <= drive;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_err)
        begin
            deriv_reg <= deriv_next;
        end
        if (ctl.load_mult)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
        if (ctl.load_sum)
        begin
            u_reg <= u_next;
        end
    end

endmodule
